>>> design/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

    // Number of keys the queue can hold (one cell per key).
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int FILL_W   = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic signed [KEY_W-1:0] key_in;
    } t_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic                    was_empty;
        logic                    overflow;
        logic [FILL_W-1:0]       fill_count;
    } t_result;

    // Broadcast command to every cell.
    typedef struct packed {
        logic                    push;
        logic                    pop;
        logic signed [KEY_W-1:0] key;
    } t_cell_op;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic                    gt;
        logic signed [KEY_W-1:0] key;
    } t_cell_link;

endpackage

`default_nettype wire

>>> design/mpq_cell.sv
`default_nettype none

module mpq_cell (
    input  wire                                 i_clk,
    input  wire mpq_pkg::t_cell_op              i_op,
    input  wire logic                           i_occupied,
    input  wire mpq_pkg::t_cell_link            i_left,
    input  wire logic signed [mpq_pkg::KEY_W-1:0] i_right_key,
    output mpq_pkg::t_cell_link                 o_link
);

    logic signed [mpq_pkg::KEY_W-1:0] r_key;
    logic signed [mpq_pkg::KEY_W-1:0] n_key;
    logic                             w_gt;

    // Empty cells count as larger than any key, so the gt flags along the
    // row read 0...0 1...1 and the first 1 marks the insert position.
    assign w_gt = !i_occupied || (r_key > i_op.key);

    assign o_link.gt  = w_gt;
    assign o_link.key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_op.push && w_gt) begin
            n_key = i_left.gt ? i_left.key : i_op.key;
        end else if (i_op.pop) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

>>> design/min_priority_queue.sv
// Latency: the result of an item is on o_result, with o_valid high, in the
//   cycle after start is taken; it is shown for that one cycle only.
// Throughput: one item per cycle; busy stays low, every cell updates in the
//   same cycle as its neighbors, so no item waits on an earlier one.
// Reset (synchronous, active low) clears the key count and the result strobe;
//   the key cells keep their contents, which count as empty. No stall input.
`default_nettype none

module min_priority_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire mpq_pkg::t_item i_item,
    output logic                busy,
    output logic                o_valid,
    output mpq_pkg::t_result    o_result
);

    localparam int N = mpq_pkg::CAPACITY;

    logic                        w_accept;
    logic                        w_full;
    logic                        w_empty;
    mpq_pkg::t_cell_op           w_op;
    logic [mpq_pkg::CNT_W-1:0]   r_count;
    logic [mpq_pkg::CNT_W-1:0]   n_count;
    logic                        r_valid;
    mpq_pkg::t_result            r_result;
    mpq_pkg::t_result            n_result;

    // Links between cells; index N-1 is the tail cell.
    mpq_pkg::t_cell_link         w_link [N];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == mpq_pkg::CNT_W'(N));
    assign w_empty  = (r_count == '0);

    // Drops on full and empty pops leave the cells untouched.
    assign w_op.push = w_accept && (i_item.opcode == mpq_pkg::OP_PUSH) && !w_full;
    assign w_op.pop  = w_accept && (i_item.opcode == mpq_pkg::OP_POP) && !w_empty;
    assign w_op.key  = i_item.key_in;

    // The cells form the sorted row: cell 0 holds the smallest key.
    // A push shifts the tail of larger keys one place right and drops the new
    // key into the gap; a pop shifts every key one place left.
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        mpq_pkg::t_cell_link              w_left;
        logic signed [mpq_pkg::KEY_W-1:0] w_right_key;
        logic                             w_occ;

        assign w_occ = (mpq_pkg::CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_head
            assign w_left.gt  = 1'b0;
            assign w_left.key = '0;
        end else begin : g_body
            assign w_left = w_link[gi-1];
        end

        if (gi == N - 1) begin : g_tail
            assign w_right_key = '0;
        end else begin : g_inner
            assign w_right_key = w_link[gi+1].key;
        end

        mpq_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_occupied  (w_occ),
            .i_left      (w_left),
            .i_right_key (w_right_key),
            .o_link      (w_link[gi])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_op.push) begin
            n_count = r_count + 1'b1;
        end else if (w_op.pop) begin
            n_count = r_count - 1'b1;
        end

        n_result            = '0;
        n_result.key_out    = w_op.pop ? w_link[0].key : '0;
        n_result.was_empty  = w_accept && (i_item.opcode == mpq_pkg::OP_POP) && w_empty;
        n_result.overflow   = w_accept && (i_item.opcode == mpq_pkg::OP_PUSH) && w_full;
        n_result.fill_count = mpq_pkg::FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Count never exceeds the number of cells.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mpq_pkg::CNT_W'(N))
        else $error("key count above capacity");

    // Each accepted item yields exactly one result on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted item produced no result");

    // A taken push grows the count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.push |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow count");

    // The two smallest keys stay in order.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= mpq_pkg::CNT_W'(2)) |-> (w_link[0].key <= w_link[1].key))
        else $error("head cells out of order");

    // A result never flags both an empty pop and a dropped push.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.was_empty && o_result.overflow))
        else $error("both empty and overflow flags set");

endmodule

`default_nettype wire

>>> sim/min_priority_queue_checker.sv
`timescale 1ns / 1ps

// Watches both sides of min_priority_queue, keeps its own sorted copy of the
// queue and compares every result with the oldest pending prediction.
module min_priority_queue_checker (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire                   i_busy,
    input  wire mpq_pkg::t_item   i_item,
    input  wire                   i_valid,
    input  wire mpq_pkg::t_result i_result,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic signed [mpq_pkg::KEY_W-1:0] held_keys [mpq_pkg::CAPACITY];
    int                               held_count;
    mpq_pkg::t_result                 pending_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        held_count   = 0;
    end

    task automatic report_fail(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    // Sorted insert on push, remove head on pop; equal keys keep arrival order.
    function automatic mpq_pkg::t_result apply_item(input mpq_pkg::t_item it);
        mpq_pkg::t_result r;
        int               pos;
        r = '0;
        if (it.opcode == mpq_pkg::OP_PUSH) begin
            if (held_count >= mpq_pkg::CAPACITY) begin
                r.overflow = 1'b1;
            end else begin
                pos = held_count;
                while (pos > 0 && $signed(held_keys[pos-1]) > $signed(it.key_in)) begin
                    held_keys[pos] = held_keys[pos-1];
                    pos--;
                end
                held_keys[pos] = it.key_in;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.was_empty = 1'b1;
            end else begin
                r.key_out = held_keys[0];
                for (int i = 1; i < held_count; i++) begin
                    held_keys[i-1] = held_keys[i];
                end
                held_count--;
            end
        end
        r.fill_count = mpq_pkg::FILL_W'(held_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        mpq_pkg::t_result want;
        if (!i_rst_n) begin
            held_count = 0;
            pending_results.delete();
        end else begin
            // Result first: it belongs to an item taken at an earlier edge.
            if (i_valid === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_fail($sformatf("result with nothing pending: key_out %0d fill %0d",
                                          i_result.key_out, i_result.fill_count));
                end else begin
                    want = pending_results.pop_front();
                    if (i_result.key_out !== want.key_out)
                        report_fail($sformatf("key_out %0d, expected %0d",
                                              i_result.key_out, want.key_out));
                    if (i_result.was_empty !== want.was_empty)
                        report_fail($sformatf("was_empty %b, expected %b",
                                              i_result.was_empty, want.was_empty));
                    if (i_result.overflow !== want.overflow)
                        report_fail($sformatf("overflow %b, expected %b",
                                              i_result.overflow, want.overflow));
                    if (i_result.fill_count !== want.fill_count)
                        report_fail($sformatf("fill_count %0d, expected %0d",
                                              i_result.fill_count, want.fill_count));
                end
            end
            if (i_start && !i_busy)
                pending_results.push_back(apply_item(i_item));
        end
        o_pending = pending_results.size();
    end

endmodule

>>> sim/min_priority_queue_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for min_priority_queue. All prediction and comparison
// lives in min_priority_queue_checker; this module only drives items.
module min_priority_queue_tb;

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 1030;
    // Longest quiet stretch in a good run is a capped sender gap or the short
    // drain at the end; this leaves plenty of margin.
    localparam int STALL_LIMIT  = 500;
    localparam int MAX_GAP      = 12;
    localparam int IDLE_PCT     = 38;

    localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    mpq_pkg::t_item   item;
    logic             busy;
    logic             valid;
    mpq_pkg::t_result result;

    int      fail_count;
    int      pending;
    int      stall_cycles = 0;
    logic    idling_on;

    always #(CLK_PERIOD / 2) clk = ~clk;

    min_priority_queue dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .i_item   (item),
        .busy     (busy),
        .o_valid  (valid),
        .o_result (result)
    );

    min_priority_queue_checker checker_u (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_valid      (valid),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: counts cycles where neither an item nor a result moves.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("min_priority_queue_tb failed");
        $finish;
    end

    // Key mix: extremes, a narrow band that forces duplicates, and full-range
    // random values so every key bit toggles.
    function automatic logic signed [mpq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2:       return '0;
            3:       return -32'sd1;
            4, 5:    return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    // Optional random idle cycles (start low, junk on the bus), then hold the
    // item until it is taken. Inputs move only on falling edges.
    task automatic send_item(input logic op, input logic signed [mpq_pkg::KEY_W-1:0] key);
        int gap;
        gap = 0;
        if (idling_on) begin
            while (gap < MAX_GAP && $urandom_range(99) < IDLE_PCT)
                gap++;
        end
        repeat (gap) begin
            @(negedge clk);
            start <= 1'b0;
            item  <= {1'($urandom), 32'($urandom)};
        end
        @(negedge clk);
        start       <= 1'b1;
        item.opcode <= op;
        item.key_in <= key;
        do @(posedge clk); while (busy);
    endtask

    initial begin
        int n;
        int burst;
        int push_pct;

        start     = 1'b0;
        item      = '0;
        rst_n     = 1'b0;
        idling_on = 1'b1;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: pop on empty, extreme keys, duplicates, a negative key
        // with alternating bits, drain to empty and pop past it.
        send_item(mpq_pkg::OP_POP,  pick_key());
        send_item(mpq_pkg::OP_PUSH, '0);
        send_item(mpq_pkg::OP_PUSH, KEY_MAX);
        send_item(mpq_pkg::OP_PUSH, KEY_MIN);
        send_item(mpq_pkg::OP_PUSH, -32'sd1);
        send_item(mpq_pkg::OP_PUSH, 32'sd1);
        send_item(mpq_pkg::OP_PUSH, 32'sd1);
        send_item(mpq_pkg::OP_PUSH, KEY_MIN);
        send_item(mpq_pkg::OP_POP,  KEY_MAX);
        send_item(mpq_pkg::OP_POP,  '0);
        send_item(mpq_pkg::OP_POP,  -32'sd1);
        send_item(mpq_pkg::OP_PUSH, 32'sh5555_5555);
        send_item(mpq_pkg::OP_PUSH, 32'shAAAA_AAAA);
        send_item(mpq_pkg::OP_POP,  32'sh5555_5555);
        repeat (5) send_item(mpq_pkg::OP_POP, pick_key());
        send_item(mpq_pkg::OP_POP,  pick_key());
        send_item(mpq_pkg::OP_PUSH, KEY_MAX);
        send_item(mpq_pkg::OP_POP,  KEY_MIN);

        // Random: bursts that fill (and overflow), drain (and underflow) or
        // mix, so the queue swings between empty and full many times.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            burst = $urandom_range(30, 140);
            if (burst > RANDOM_ITEMS - n)
                burst = RANDOM_ITEMS - n;
            case ($urandom_range(2))
                0:       push_pct = 90;
                1:       push_pct = 10;
                default: push_pct = 50;
            endcase
            repeat (burst) begin
                // Back-to-back stretch with no sender gaps.
                idling_on = !(n >= 400 && n < 650);
                send_item(($urandom_range(99) < push_pct) ? mpq_pkg::OP_PUSH : mpq_pkg::OP_POP,
                          pick_key());
                n++;
            end
        end

        @(negedge clk);
        start <= 1'b0;

        wait (pending == 0);
        repeat (4) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("min_priority_queue_tb passed");
        end else begin
            $display("min_priority_queue_tb failed");
        end
        $finish;
    end

endmodule
